/* rtl/sn_pkg.sv */
// Shared constants, types and fixed-point coefficients for the fractal noise engine.
package sn_pkg;

  localparam int TABLE_SIZE      = 256;
  localparam int MAX_OCTAVES     = 8;
  localparam int COORD_FRAC_BITS = 16;

  localparam int ADDR_W = $clog2(TABLE_SIZE);
  localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
  localparam int QB     = 28;
  localparam int TQ     = QB - COORD_FRAC_BITS;
  localparam int S3_SHIFT = 5;

  // shared multiplier: 64 x 16 partial product per step
  localparam int MUL_CHUNK = 16;
  localparam int MUL_STEPS = 64 / MUL_CHUNK;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  // request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [1:0] DIM_NONE = 2'd0;
  localparam logic [1:0] DIM_1D   = 2'd1;
  localparam logic [1:0] DIM_2D   = 2'd2;
  localparam logic [1:0] DIM_3D   = 2'd3;

  typedef logic signed [63:0] q_t;

  localparam q_t QONE    = 64'sd1 <<< QB;
  localparam q_t K_F2    = q_t'(((64'd366025403 << QB) + 64'd500000000) / 64'd1000000000);
  localparam q_t K_G2    = q_t'(((64'd211324865 << QB) + 64'd500000000) / 64'd1000000000);
  localparam q_t K_G2X2  = q_t'(((64'd57735027 << QB) + 64'd50000000) / 64'd100000000);
  localparam q_t K_F3    = q_t'(((64'd1 << QB) + 64'd1) / 64'd3);
  localparam q_t K_G3    = q_t'(((64'd1 << QB) + 64'd3) / 64'd6);
  localparam q_t K_G3X2  = K_G3 * 2;
  localparam q_t K_G3X3  = K_G3 * 3;
  localparam q_t K_R2    = q_t'(((64'd1 << QB) + 64'd1) / 64'd2);
  localparam q_t K_R3    = q_t'(((64'd6 << QB) + 64'd5) / 64'd10);
  localparam q_t K_S1    = q_t'(((64'd395 << QB) + 64'd500) / 64'd1000);
  localparam q_t K_S2    = q_t'(((64'd4523065 << QB) + 64'd50000) / 64'd100000);
  localparam q_t SAT_MAX = 64'sd2147483647;
  localparam q_t SAT_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_ZERO,
    KIND_EVAL
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [1:0]        dims;
    logic [OCT_W-1:0]  octaves;
    logic [31:0]       cx;
    logic [31:0]       cy;
    logic [31:0]       cz;
    logic [ADDR_W-1:0] idx;
    logic [7:0]        val;
  } item_t;

  typedef struct packed {
    logic        start;
    logic        shift;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } mul_rsp_t;

endpackage

/* rtl/simplex_noise_fractal.sv */
// Fractal simplex noise engine: top level joining the request queue and the evaluator.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------------
//   input   | in_valid_i/in_stall_o | command, dims, octave_count, coord_x/y/z,
//           |                       | table_index, table_value
//   output  | out_valid_o/out_stall_i | noise_value (Q4.28), evaluate requests only
//
// An evaluate runs octaves one after another on a single 64x16 multiplier.
// Reset clears control state only; the permutation table holds garbage until loaded.
// A two-entry queue keeps taking requests while the evaluator works or the
// result register waits on out_stall_i.
module simplex_noise_fractal (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [1:0]         dims_i,
  input  logic [3:0]         octave_count_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [7:0]         table_index_i,
  input  logic [7:0]         table_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] noise_value_o
);
  import sn_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  sn_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .dims_i         (dims_i),
    .octave_count_i (octave_count_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .coord_z_i      (coord_z_i),
    .table_index_i  (table_index_i),
    .table_value_i  (table_value_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  sn_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .noise_value_o (noise_value_o)
  );

endmodule

/* rtl/sn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sn_mul.sv */
// Shared multi-cycle multiplier: low 64 bits of a*b, optionally floor-shifted by QB.
module sn_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sn_pkg::mul_req_t req_i,
  output sn_pkg::mul_rsp_t rsp_o
);
  import sn_pkg::*;

  logic [63:0]          a_q, b_q, acc_q, res_q;
  logic [63:0]          pp, acc_n;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q, shift_q;

  assign pp    = a_q * 64'(b_q[MUL_CHUNK-1:0]);
  assign acc_n = acc_q + pp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q     <= req_i.a;
      b_q     <= req_i.b;
      acc_q   <= '0;
      shift_q <= req_i.shift;
    end else if (busy_q) begin
      a_q   <= a_q << MUL_CHUNK;
      b_q   <= b_q >> MUL_CHUNK;
      acc_q <= acc_n;
      // low 64 bits are the same for signed and unsigned operands
      res_q <= shift_q ? 64'($signed(acc_n) >>> QB) : acc_n;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

/* rtl/sn_front.sv */
// Front end: takes requests, classifies them and holds them in a short queue.
module sn_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      command_i,
  input  logic [1:0]                dims_i,
  input  logic [3:0]                octave_count_i,
  input  logic signed [31:0]        coord_x_i,
  input  logic signed [31:0]        coord_y_i,
  input  logic signed [31:0]        coord_z_i,
  input  logic [7:0]                table_index_i,
  input  logic [7:0]                table_value_i,
  output logic                      q_valid_o,
  output sn_pkg::item_t             q_item_o,
  input  logic                      q_pop_i
);
  import sn_pkg::*;

  item_t             mem_q [QDEPTH];
  item_t             item;
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push;
  logic [OCT_W-1:0]  oct_sat;

  assign in_stall_o = (cnt_q == QCNT_W'(QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_q];

  always_comb begin
    if (32'(octave_count_i) > MAX_OCTAVES) begin
      oct_sat = OCT_W'(MAX_OCTAVES);
    end else begin
      oct_sat = OCT_W'(octave_count_i);
    end
    item.dims    = dims_i;
    item.octaves = oct_sat;
    item.cx      = coord_x_i;
    item.cy      = coord_y_i;
    item.cz      = coord_z_i;
    item.idx     = table_index_i;
    item.val     = table_value_i;
    if (command_i == CMD_LOAD) begin
      item.kind = KIND_LOAD;
    end else if (dims_i == DIM_NONE || oct_sat == '0) begin
      item.kind = KIND_ZERO;
    end else begin
      item.kind = KIND_EVAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item;
    end
  end

endmodule

/* rtl/sn_back.sv */
// Back end: octave/corner sequencer over the shared multiplier and the permutation RAM.
module sn_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  sn_pkg::item_t      q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] noise_value_o
);
  import sn_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LOAD   = 5'd1;
  localparam logic [4:0] S_OCT    = 5'd2;
  localparam logic [4:0] S_SKEW   = 5'd3;
  localparam logic [4:0] S_UNSKEW = 5'd4;
  localparam logic [4:0] S_CSET   = 5'd5;
  localparam logic [4:0] S_HADDR  = 5'd6;
  localparam logic [4:0] S_HDATA  = 5'd7;
  localparam logic [4:0] S_SQX    = 5'd8;
  localparam logic [4:0] S_RX     = 5'd9;
  localparam logic [4:0] S_RY     = 5'd10;
  localparam logic [4:0] S_RZ     = 5'd11;
  localparam logic [4:0] S_CLIP   = 5'd12;
  localparam logic [4:0] S_T2     = 5'd13;
  localparam logic [4:0] S_T4     = 5'd14;
  localparam logic [4:0] S_G1     = 5'd15;
  localparam logic [4:0] S_ACC    = 5'd16;
  localparam logic [4:0] S_NEXT   = 5'd17;
  localparam logic [4:0] S_FIN    = 5'd18;
  localparam logic [4:0] S_OACC   = 5'd19;
  localparam logic [4:0] S_DONE   = 5'd20;
  localparam logic [4:0] S_MULW   = 5'd21;

  logic [4:0] state_q, state_d, ret_q, ret_d;

  logic [1:0]         dims_q, dims_d;
  logic [OCT_W-1:0]   oct_q, oct_d, o_q, o_d;
  logic [31:0]        cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic [7:0]         val_q, val_d;
  logic signed [31:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [1:0]         c_q, c_d, lv_q, lv_d;
  logic [2:0]         hb_q, hb_d;
  logic [7:0]         prev_q, prev_d, h_q, h_d;
  q_t ri_q, ri_d, rj_q, rj_d, rk_q, rk_d;
  q_t x0_q, x0_d, y0_q, y0_d, z0_q, z0_d;
  q_t ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  q_t t_q, t_d, n_q, n_d, acc_q, acc_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_q, out_d;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  q_t       m;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // working values
  logic signed [31:0] pxw, pyw, pzw;
  q_t                 sx, sy, sz, six, siy, siz;
  logic               i1, ge_xy, ge_yz, ge_xz;
  logic [2:0]         o1, o2, cbits;
  q_t                 cadd, radius, grad, gu, gv;
  logic [7:0]         axis;
  logic               abit;
  logic [5:0]         h6;
  logic [3:0]         h4;

  assign m = q_t'(mrsp.res);

  sn_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  sn_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_SIZE)
  ) u_perm (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (val_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    pxw = cx_q << o_q;
    pyw = cy_q << o_q;
    pzw = cz_q << o_q;
    sx  = q_t'(px_q) + m;
    sy  = q_t'(py_q) + m;
    sz  = q_t'(pz_q) + m;
    six = sx >>> COORD_FRAC_BITS;
    siy = sy >>> COORD_FRAC_BITS;
    siz = sz >>> COORD_FRAC_BITS;

    // simplex corner order
    i1    = x0_q > y0_q;
    ge_xy = x0_q >= y0_q;
    ge_yz = y0_q >= z0_q;
    ge_xz = x0_q >= z0_q;
    if (ge_xy) begin
      if (ge_yz) begin
        o1 = 3'b100; o2 = 3'b110;
      end else if (ge_xz) begin
        o1 = 3'b100; o2 = 3'b101;
      end else begin
        o1 = 3'b001; o2 = 3'b101;
      end
    end else begin
      if (!ge_yz) begin
        o1 = 3'b001; o2 = 3'b011;
      end else if (!ge_xz) begin
        o1 = 3'b010; o2 = 3'b011;
      end else begin
        o1 = 3'b010; o2 = 3'b110;
      end
    end

    cbits  = 3'b000;
    cadd   = '0;
    radius = K_R3;
    case (dims_q)
      DIM_1D: begin
        cbits  = {c_q[0], 2'b00};
        radius = QONE;
      end
      DIM_2D: begin
        radius = K_R2;
        case (c_q)
          2'd0: cbits = 3'b000;
          2'd1: begin
            cbits = {i1, ~i1, 1'b0};
            cadd  = K_G2;
          end
          default: begin
            // far corner hashes at +1,+1 but is offset by the skew term alone
            cbits = 3'b110;
            cadd  = QONE - K_G2X2;
          end
        endcase
      end
      DIM_3D: begin
        case (c_q)
          2'd0: cbits = 3'b000;
          2'd1: begin
            cbits = o1;
            cadd  = K_G3;
          end
          2'd2: begin
            cbits = o2;
            cadd  = K_G3X2;
          end
          default: begin
            cbits = 3'b111;
            cadd  = K_G3X3;
          end
        endcase
      end
      default: ;
    endcase

    // hash chain runs k, then j, then i
    case (lv_q)
      2'd2: begin
        axis = rk_q[7:0];
        abit = hb_q[0];
      end
      2'd1: begin
        axis = rj_q[7:0];
        abit = hb_q[1];
      end
      default: begin
        axis = ri_q[7:0];
        abit = hb_q[2];
      end
    endcase
    ram_raddr = ADDR_W'(axis + {7'd0, abit} + prev_q);

    h6 = h_q[5:0];
    h4 = h_q[3:0];
    if (dims_q == DIM_2D) begin
      gu = (h6 < 6'd4) ? ox_q : oy_q;
      gv = (h6 < 6'd4) ? oy_q : ox_q;
      gv = gv <<< 1;
    end else begin
      gu = (h4 < 4'd8) ? ox_q : oy_q;
      if (h4 < 4'd4) begin
        gv = oy_q;
      end else if (h4 == 4'd12 || h4 == 4'd14) begin
        gv = ox_q;
      end else begin
        gv = oz_q;
      end
    end
    grad = (h_q[0] ? -gu : gu) + (h_q[1] ? -gv : gv);
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    dims_d  = dims_q;
    oct_d   = oct_q;
    o_d     = o_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cz_d    = cz_q;
    idx_d   = idx_q;
    val_d   = val_q;
    px_d    = px_q;
    py_d    = py_q;
    pz_d    = pz_q;
    c_d     = c_q;
    lv_d    = lv_q;
    hb_d    = hb_q;
    prev_d  = prev_q;
    h_d     = h_q;
    ri_d    = ri_q;
    rj_d    = rj_q;
    rk_d    = rk_q;
    x0_d    = x0_q;
    y0_d    = y0_q;
    z0_d    = z0_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    oz_d    = oz_q;
    t_d     = t_q;
    n_d     = n_q;
    acc_d   = acc_q;
    out_d   = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    q_pop_o    = 1'b0;
    ram_we     = 1'b0;
    mreq.start = 1'b0;
    mreq.shift = 1'b1;
    mreq.a     = '0;
    mreq.b     = '0;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          dims_d  = q_item_i.dims;
          oct_d   = q_item_i.octaves;
          cx_d    = q_item_i.cx;
          cy_d    = q_item_i.cy;
          cz_d    = q_item_i.cz;
          idx_d   = q_item_i.idx;
          val_d   = q_item_i.val;
          acc_d   = '0;
          o_d     = '0;
          case (q_item_i.kind)
            KIND_LOAD: state_d = S_LOAD;
            KIND_ZERO: state_d = S_DONE;
            default:   state_d = S_OCT;
          endcase
        end
      end
      S_LOAD: begin
        ram_we  = 1'b1;
        state_d = S_IDLE;
      end
      S_OCT: begin
        if (o_q == oct_q) begin
          state_d = S_DONE;
        end else begin
          px_d = pxw;
          py_d = pyw;
          pz_d = pzw;
          n_d  = '0;
          c_d  = '0;
          if (dims_q == DIM_1D) begin
            ri_d    = q_t'(pxw) >>> COORD_FRAC_BITS;
            x0_d    = (q_t'(pxw) <<< TQ) - ((q_t'(pxw) >>> COORD_FRAC_BITS) <<< QB);
            state_d = S_CSET;
          end else begin
            mreq.start = 1'b1;
            mreq.a     = q_t'(pxw) + q_t'(pyw) + ((dims_q == DIM_3D) ? q_t'(pzw) : '0);
            mreq.b     = (dims_q == DIM_2D) ? K_F2 : K_F3;
            ret_d      = S_SKEW;
            state_d    = S_MULW;
          end
        end
      end
      S_SKEW: begin
        ri_d       = six;
        rj_d       = siy;
        rk_d       = siz;
        mreq.start = 1'b1;
        mreq.shift = 1'b0;
        mreq.a     = six + siy + ((dims_q == DIM_3D) ? siz : '0);
        mreq.b     = (dims_q == DIM_2D) ? K_G2 : K_G3;
        ret_d      = S_UNSKEW;
        state_d    = S_MULW;
      end
      S_UNSKEW: begin
        x0_d    = (q_t'(px_q) <<< TQ) - (ri_q <<< QB) + m;
        y0_d    = (q_t'(py_q) <<< TQ) - (rj_q <<< QB) + m;
        z0_d    = (q_t'(pz_q) <<< TQ) - (rk_q <<< QB) + m;
        state_d = S_CSET;
      end
      S_CSET: begin
        ox_d    = x0_q - (cbits[2] ? QONE : '0) + cadd;
        oy_d    = y0_q - (cbits[1] ? QONE : '0) + cadd;
        oz_d    = z0_q - (cbits[0] ? QONE : '0) + cadd;
        hb_d    = cbits;
        lv_d    = dims_q - 2'd1;
        prev_d  = '0;
        state_d = S_HADDR;
      end
      S_HADDR: state_d = S_HDATA;
      S_HDATA: begin
        prev_d = ram_rdata;
        if (lv_q == 2'd0) begin
          h_d     = ram_rdata;
          state_d = S_SQX;
        end else begin
          lv_d    = lv_q - 2'd1;
          state_d = S_HADDR;
        end
      end
      S_SQX: begin
        mreq.start = 1'b1;
        mreq.a     = ox_q;
        mreq.b     = ox_q;
        ret_d      = S_RX;
        state_d    = S_MULW;
      end
      S_RX: begin
        t_d = radius - m;
        if (dims_q == DIM_1D) begin
          state_d = S_CLIP;
        end else begin
          mreq.start = 1'b1;
          mreq.a     = oy_q;
          mreq.b     = oy_q;
          ret_d      = S_RY;
          state_d    = S_MULW;
        end
      end
      S_RY: begin
        t_d = t_q - m;
        if (dims_q == DIM_2D) begin
          state_d = S_CLIP;
        end else begin
          mreq.start = 1'b1;
          mreq.a     = oz_q;
          mreq.b     = oz_q;
          ret_d      = S_RZ;
          state_d    = S_MULW;
        end
      end
      S_RZ: begin
        t_d     = t_q - m;
        state_d = S_CLIP;
      end
      S_CLIP: begin
        if (t_q < 0) begin
          state_d = S_NEXT;
        end else begin
          mreq.start = 1'b1;
          mreq.a     = t_q;
          mreq.b     = t_q;
          ret_d      = S_T2;
          state_d    = S_MULW;
        end
      end
      S_T2: begin
        mreq.start = 1'b1;
        mreq.a     = m;
        mreq.b     = m;
        ret_d      = S_T4;
        state_d    = S_MULW;
      end
      S_T4: begin
        t_d        = m;
        mreq.start = 1'b1;
        state_d    = S_MULW;
        if (dims_q == DIM_1D) begin
          // 1-D gradient is (1 + h[2:0]) * x, a plain product
          mreq.shift = 1'b0;
          mreq.a     = ox_q;
          mreq.b     = q_t'(h_q[2:0]) + 64'sd1;
          ret_d      = S_G1;
        end else begin
          mreq.a = m;
          mreq.b = grad;
          ret_d  = S_ACC;
        end
      end
      S_G1: begin
        mreq.start = 1'b1;
        mreq.a     = t_q;
        mreq.b     = h_q[3] ? -m : m;
        ret_d      = S_ACC;
        state_d    = S_MULW;
      end
      S_ACC: begin
        n_d     = n_q + m;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        // last corner index equals the dimension
        if (c_q == dims_q) begin
          state_d = S_FIN;
        end else begin
          c_d     = c_q + 2'd1;
          state_d = S_CSET;
        end
      end
      S_FIN: begin
        if (dims_q == DIM_3D) begin
          acc_d   = acc_q + ((n_q <<< S3_SHIFT) >>> o_q);
          o_d     = o_q + 1'b1;
          state_d = S_OCT;
        end else begin
          mreq.start = 1'b1;
          mreq.a     = (dims_q == DIM_1D) ? K_S1 : K_S2;
          mreq.b     = n_q;
          ret_d      = S_OACC;
          state_d    = S_MULW;
        end
      end
      S_OACC: begin
        acc_d   = acc_q + (m >>> o_q);
        o_d     = o_q + 1'b1;
        state_d = S_OCT;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (acc_q > SAT_MAX) begin
            out_d = 32'sh7FFFFFFF;
          end else if (acc_q < SAT_MIN) begin
            out_d = 32'sh80000000;
          end else begin
            out_d = acc_q[31:0];
          end
          state_d = S_IDLE;
        end
      end
      S_MULW: begin
        if (mrsp.done) begin
          state_d = ret_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dims_q <= dims_d;
    oct_q  <= oct_d;
    o_q    <= o_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    cz_q   <= cz_d;
    idx_q  <= idx_d;
    val_q  <= val_d;
    px_q   <= px_d;
    py_q   <= py_d;
    pz_q   <= pz_d;
    c_q    <= c_d;
    lv_q   <= lv_d;
    hb_q   <= hb_d;
    prev_q <= prev_d;
    h_q    <= h_d;
    ri_q   <= ri_d;
    rj_q   <= rj_d;
    rk_q   <= rk_d;
    x0_q   <= x0_d;
    y0_q   <= y0_d;
    z0_q   <= z0_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    oz_q   <= oz_d;
    t_q    <= t_d;
    n_q    <= n_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = out_q;

`ifndef SYNTHESIS
  a_mul_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mrsp.done |-> state_q == S_MULW)
    else $error("multiplier finished while sequencer was not waiting");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside the completion step");

  a_octave_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OCT |-> o_q <= oct_q)
    else $error("octave index ran past the octave count");

  a_corner_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CSET |-> c_q <= dims_q)
    else $error("corner index ran past the simplex");
`endif

endmodule

/* dv/simplex_noise_fractal_tb.sv */
// Self-checking testbench for the fractal simplex noise engine.
module simplex_noise_fractal_tb;
  import sn_pkg::*;

  typedef struct {
    logic        cmd;
    logic [1:0]  dims;
    logic [3:0]  oct;
    logic [31:0] x, y, z;
    logic [7:0]  idx, val;
    bit          barrier;  // wait for all results before offering this request
  } req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic command_i = CMD_LOAD;
  logic [1:0] dims_i = DIM_NONE;
  logic [3:0] octave_count_i = '0;
  logic signed [31:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic [7:0] table_index_i = '0, table_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] noise_value_o;

  simplex_noise_fractal dut (.*);

  always #4 clk_i = ~clk_i;

  req_t        req_q[$];
  logic [31:0] noise_q[$];
  logic [7:0]  perm[TABLE_SIZE];
  int          errors = 0;
  int          results = 0;
  int          in_gap = 0;
  int          out_wait = 0;
  bit          burst = 1'b0;
  bit          long_hold = 1'b0;

  function automatic longint qm(longint a, longint b);
    return (a * b) >>> QB;
  endfunction

  function automatic longint hsh(longint v);
    return longint'(perm[v[7:0]]);
  endfunction

  function automatic longint grad1(longint h, longint x);
    longint r;
    r = ((h & 7) + 1) * x;
    return h[3] ? -r : r;
  endfunction

  function automatic longint n1d(longint x);
    longint i, f, fm, t0, t1;
    i = x >>> COORD_FRAC_BITS;
    f = (x <<< TQ) - i * QONE;
    fm = f - QONE;
    t0 = QONE - qm(f, f);
    t1 = QONE - qm(fm, fm);
    t0 = qm(t0, t0); t0 = qm(t0, t0);
    t1 = qm(t1, t1); t1 = qm(t1, t1);
    return qm(K_S1, qm(t0, grad1(hsh(i), f)) + qm(t1, grad1(hsh(i + 1), fm)));
  endfunction

  function automatic longint c2d(longint h, longint x, longint y);
    longint t, u, v;
    t = K_R2 - qm(x, x) - qm(y, y);
    if (t < 0) return 0;
    h = h & 'h3F;
    u = (h < 4) ? x : y;
    v = (h < 4) ? y : x;
    t = qm(t, t);
    t = qm(t, t);
    return qm(t, (h[0] ? -u : u) + (h[1] ? -2 * v : 2 * v));
  endfunction

  function automatic longint n2d(longint x, longint y);
    longint s, i, j, t, x0, y0, i1, j1, n;
    s = ((x + y) * K_F2) >>> QB;
    i = (x + s) >>> COORD_FRAC_BITS;
    j = (y + s) >>> COORD_FRAC_BITS;
    t = (i + j) * K_G2;
    x0 = (x <<< TQ) - i * QONE + t;
    y0 = (y <<< TQ) - j * QONE + t;
    i1 = (x0 > y0) ? 1 : 0;
    j1 = 1 - i1;
    n = c2d(hsh(i + hsh(j)), x0, y0);
    n += c2d(hsh(i + i1 + hsh(j + j1)), x0 - i1 * QONE + K_G2, y0 - j1 * QONE + K_G2);
    n += c2d(hsh(i + 1 + hsh(j + 1)), x0 - K_G2X2, y0 - K_G2X2);
    return qm(K_S2, n);
  endfunction

  function automatic longint c3d(longint h, longint x, longint y, longint z);
    longint t, u, v;
    t = K_R3 - qm(x, x) - qm(y, y) - qm(z, z);
    if (t < 0) return 0;
    h = h & 'hF;
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    t = qm(t, t);
    t = qm(t, t);
    return qm(t, (h[0] ? -u : u) + (h[1] ? -v : v));
  endfunction

  function automatic longint n3d(longint x, longint y, longint z);
    longint s, i, j, k, t, x0, y0, z0, n;
    longint i1, j1, k1, i2, j2, k2;
    s = ((x + y + z) * K_F3) >>> QB;
    i = (x + s) >>> COORD_FRAC_BITS;
    j = (y + s) >>> COORD_FRAC_BITS;
    k = (z + s) >>> COORD_FRAC_BITS;
    t = (i + j + k) * K_G3;
    x0 = (x <<< TQ) - i * QONE + t;
    y0 = (y <<< TQ) - j * QONE + t;
    z0 = (z <<< TQ) - k * QONE + t;
    if (x0 >= y0) begin
      if (y0 >= z0)      {i1, j1, k1, i2, j2, k2} = {64'd1, 64'd0, 64'd0, 64'd1, 64'd1, 64'd0};
      else if (x0 >= z0) {i1, j1, k1, i2, j2, k2} = {64'd1, 64'd0, 64'd0, 64'd1, 64'd0, 64'd1};
      else               {i1, j1, k1, i2, j2, k2} = {64'd0, 64'd0, 64'd1, 64'd1, 64'd0, 64'd1};
    end else begin
      if (y0 < z0)       {i1, j1, k1, i2, j2, k2} = {64'd0, 64'd0, 64'd1, 64'd0, 64'd1, 64'd1};
      else if (x0 < z0)  {i1, j1, k1, i2, j2, k2} = {64'd0, 64'd1, 64'd0, 64'd0, 64'd1, 64'd1};
      else               {i1, j1, k1, i2, j2, k2} = {64'd0, 64'd1, 64'd0, 64'd1, 64'd1, 64'd0};
    end
    n = c3d(hsh(i + hsh(j + hsh(k))), x0, y0, z0);
    n += c3d(hsh(i + i1 + hsh(j + j1 + hsh(k + k1))),
             x0 - i1 * QONE + K_G3, y0 - j1 * QONE + K_G3, z0 - k1 * QONE + K_G3);
    n += c3d(hsh(i + i2 + hsh(j + j2 + hsh(k + k2))),
             x0 - i2 * QONE + K_G3X2, y0 - j2 * QONE + K_G3X2, z0 - k2 * QONE + K_G3X2);
    n += c3d(hsh(i + 1 + hsh(j + 1 + hsh(k + 1))),
             x0 - QONE + K_G3X3, y0 - QONE + K_G3X3, z0 - QONE + K_G3X3);
    return n * 32;
  endfunction

  function automatic logic [31:0] fbm_noise(req_t r);
    longint acc, x, y, z, n;
    int oct;
    logic [31:0] sx, sy, sz;
    acc = 0;
    oct = (r.oct > MAX_OCTAVES) ? MAX_OCTAVES : r.oct;
    for (int o = 0; o < oct && r.dims != DIM_NONE; o++) begin
      sx = r.x << o; sy = r.y << o; sz = r.z << o;
      x = longint'($signed(sx)); y = longint'($signed(sy)); z = longint'($signed(sz));
      case (r.dims)
        DIM_1D:  n = n1d(x);
        DIM_2D:  n = n2d(x, y);
        default: n = n3d(x, y, z);
      endcase
      acc += n >>> o;
    end
    if (acc > SAT_MAX) acc = SAT_MAX;
    if (acc < SAT_MIN) acc = SAT_MIN;
    return acc[31:0];
  endfunction

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    bit   launch;
    req_t r;
    launch = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        r.cmd = command_i; r.dims = dims_i; r.oct = octave_count_i;
        r.x = coord_x_i; r.y = coord_y_i; r.z = coord_z_i;
        if (command_i == CMD_LOAD) perm[table_index_i] = table_value_i;
        else noise_q.push_back(fbm_noise(r));
        in_gap = draw_gap();
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (in_gap > 0) in_gap--;
        else if (req_q.size() > 0 && (!req_q[0].barrier || noise_q.size() == 0)) begin
          r = req_q.pop_front();
          command_i <= r.cmd; dims_i <= r.dims; octave_count_i <= r.oct;
          coord_x_i <= r.x; coord_y_i <= r.y; coord_z_i <= r.z;
          table_index_i <= r.idx; table_value_i <= r.val;
          launch = 1'b1;
        end
        in_valid_i <= launch;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results++;
        if (noise_q.size() == 0) begin
          $error("noise_value: unexpected result %h", noise_value_o);
          errors++;
        end else begin
          want = noise_q.pop_front();
          if (noise_value_o !== want) begin
            $error("noise_value: expected %h, got %h", want, noise_value_o);
            errors++;
          end
        end
        out_wait = burst ? 0 : $urandom_range(0, 9);
      end
      if (out_wait > 0) out_wait--;
      out_stall_i <= long_hold || (out_wait > 0);
    end
  end

  // long hold-off on the result side so the request queue backs up
  initial begin
    wait (results >= 30);
    @(posedge clk_i);
    long_hold = 1'b1;
    repeat (4000) @(posedge clk_i);
    long_hold = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    req_t r;
    r = '{cmd: CMD_LOAD, dims: DIM_NONE, oct: 4'd0, x: '0, y: '0, z: '0,
          idx: '0, val: '0, barrier: 1'b0};
    for (int i = 0; i < TABLE_SIZE; i++) begin
      r.idx = 8'(i);
      r.val = (i == 0) ? 8'h00 : (i == 255) ? 8'hFF : 8'($urandom);
      req_q.push_back(r);
    end
    // directed evaluates: each dimension, zero/max/oversized octaves, extreme coords
    r.cmd = CMD_EVAL;
    for (int d = 0; d < 4; d++) begin
      r.dims = 2'(d);
      r.oct = 4'd1;  r.x = 32'h0; r.y = 32'h0; r.z = 32'h0;
      req_q.push_back(r);
      r.oct = 4'd0;  r.x = 32'h0001_8000; r.y = 32'h0002_4000; r.z = 32'hFFFF_0000;
      req_q.push_back(r);
      r.oct = 4'd8;  r.x = 32'h7FFF_FFFF; r.y = 32'h8000_0000; r.z = 32'h7FFF_FFFF;
      req_q.push_back(r);
      r.oct = 4'd15; r.x = 32'h8000_0000; r.y = 32'h7FFF_FFFF; r.z = 32'h8000_0000;
      req_q.push_back(r);
      r.oct = 4'd3;  r.x = 32'hFFFF_FFFF; r.y = 32'h0000_C000; r.z = 32'h0003_5555;
      req_q.push_back(r);
    end
    for (int n = 0; n < 124; n++) begin
      r.barrier = (n == 60);
      r.cmd = ($urandom_range(0, 9) == 0) ? CMD_LOAD : CMD_EVAL;
      r.dims = 2'($urandom_range(0, 3));
      r.oct = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 4));
      r.x = rand_coord(); r.y = rand_coord(); r.z = rand_coord();
      r.idx = 8'($urandom); r.val = 8'($urandom);
      req_q.push_back(r);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (req_q.size() > 0 || in_valid_i) begin
      @(posedge clk_i);
      if ($urandom_range(0, 399) == 0) burst = !burst;
    end
    burst = 1'b0;
    while (noise_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && noise_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sn_pkg.sv
rtl/sn_ram.sv
rtl/sn_mul.sv
rtl/sn_front.sv
rtl/sn_back.sv
rtl/simplex_noise_fractal.sv
dv/simplex_noise_fractal_tb.sv
